// ===== hw/rtl/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants of the four-level page table manager.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int LEVEL_BITS     = 9;
  localparam int LEVEL_COUNT    = 4;
  localparam int VPN_BITS       = LEVEL_BITS * LEVEL_COUNT;
  localparam int OUT_FRAME_BITS = 40;
  localparam int FLAG_BITS      = 3;

  localparam int BIT_PRESENT  = 0;
  localparam int BIT_WRITABLE = 1;
  localparam int BIT_USER     = 2;

  localparam logic [FLAG_BITS-1:0] LINK_FLAGS = 3'b111;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_MAP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_EXHAUSTED  = 2'd2
  } status_t;

  typedef struct packed {
    logic                      action;
    logic [VPN_BITS-1:0]       virt_page;
    logic [OUT_FRAME_BITS-1:0] frame;
    logic                      writable;
    logic                      user_access;
  } ptm_req_t;

  typedef struct packed {
    status_t                   status;
    logic                      leaf_present;
    logic                      leaf_writable;
    logic                      leaf_user;
    logic [OUT_FRAME_BITS-1:0] leaf_frame;
  } ptm_rsp_t;

endpackage

// ===== hw/rtl/ptm_ram.sv =====
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-port synchronous RAM, registered read, one access a cycle.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int WIDTH = 43,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/four_level_page_table_manager_unit.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_manager_unit
// Four-level radix page table kept in one table RAM, with lookup and map
// walks and a bump allocator for new tables.
// ----------------------------------------------------------------------------
//  channel | signals                  | payload
//  req     | req_valid, req_ready     | ptm_req_t (action, virt_page, ...)
//  rsp     | rsp_valid, rsp_ready     | ptm_rsp_t (status, leaf fields)
//
//  Each level read takes a read state and a check state; a map writes once per
//  new table and once for the leaf; rsp is loaded in the done state, and the
//  unit then returns to idle to take the next transfer. A new request is taken
//  only in idle, so walks never overlap, and every access goes through the
//  single RAM port. After reset the RAM is cleared, all TABLE_COUNT*512
//  entries, with req_ready low. A stalled rsp holds the finished walk until taken.
module four_level_page_table_manager_unit
  import ptm_pkg::*;
#(
  parameter int TABLE_COUNT = 64,
  parameter int FRAME_BITS  = 40
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ptm_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ptm_rsp_t rsp
);

  localparam int TW    = $clog2(TABLE_COUNT);
  localparam int NW    = $clog2(TABLE_COUNT + 1);
  localparam int AW    = TW + LEVEL_BITS;
  localparam int DEPTH = TABLE_COUNT * (2 ** LEVEL_BITS);
  localparam int EW    = FRAME_BITS + FLAG_BITS;

  localparam logic [NW-1:0] TC_N    = NW'(TABLE_COUNT);
  localparam logic [AW-1:0] CLR_END = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_LINK, S_LEAF, S_DONE
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_cnt;
  ptm_req_t        cur_req;
  logic [1:0]      lvl;
  logic [TW-1:0]   cur_tbl;
  logic [NW-1:0]   next_free;
  status_t         res_status;
  logic [EW-1:0]   res_leaf;

  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [EW-1:0]   mem_wdata;
  logic [EW-1:0]   mem_rdata;
  logic [EW-1:0]   link_entry;
  logic [EW-1:0]   leaf_entry;
  logic [NW-1:0]   free_cnt;
  logic [1:0]      needed;

  function automatic logic [LEVEL_BITS-1:0] level_index(logic [VPN_BITS-1:0] vp,
                                                        logic [1:0] l);
    logic [LEVEL_BITS-1:0] r;
    unique case (l)
      2'd0:    r = vp[3*LEVEL_BITS +: LEVEL_BITS];
      2'd1:    r = vp[2*LEVEL_BITS +: LEVEL_BITS];
      2'd2:    r = vp[LEVEL_BITS +: LEVEL_BITS];
      default: r = vp[0 +: LEVEL_BITS];
    endcase
    return r;
  endfunction

  assign link_entry = {FRAME_BITS'(next_free), LINK_FLAGS};
  assign leaf_entry = {cur_req.frame[FRAME_BITS-1:0], cur_req.user_access,
                       cur_req.writable, 1'b1};
  assign free_cnt   = TC_N - next_free;
  assign needed     = 2'd3 - lvl;
  assign req_ready  = (state == S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = link_entry;
    mem_addr  = {cur_tbl, level_index(cur_req.virt_page, lvl)};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_addr  = clr_cnt;
      end
      S_LINK: begin
        mem_we = 1'b1;
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = leaf_entry;
        mem_addr  = {cur_tbl, level_index(cur_req.virt_page, 2'd3)};
      end
      default: begin
      end
    endcase
  end

  ptm_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_table_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      next_free <= NW'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == CLR_END) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            cur_req <= req;
            lvl     <= 2'd0;
            cur_tbl <= '0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (lvl == 2'd3) begin
            res_status <= ST_OK;
            res_leaf   <= mem_rdata;
            state      <= S_DONE;
          end else if (mem_rdata[BIT_PRESENT]) begin
            cur_tbl <= mem_rdata[FLAG_BITS +: TW];
            lvl     <= lvl + 2'd1;
            if (cur_req.action == ACT_MAP && lvl == 2'd2) begin
              state <= S_LEAF;
            end else begin
              state <= S_READ;
            end
          end else if (cur_req.action == ACT_LOOKUP) begin
            res_status <= ST_NOT_MAPPED;
            res_leaf   <= '0;
            state      <= S_DONE;
          end else if (NW'(needed) > free_cnt) begin
            res_status <= ST_EXHAUSTED;
            res_leaf   <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          cur_tbl   <= next_free[TW-1:0];
          next_free <= next_free + NW'(1);
          lvl       <= lvl + 2'd1;
          if (lvl == 2'd2) begin
            state <= S_LEAF;
          end
        end
        S_LEAF: begin
          res_status <= ST_OK;
          res_leaf   <= leaf_entry;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.leaf_present  <= res_leaf[BIT_PRESENT];
            rsp.leaf_writable <= res_leaf[BIT_WRITABLE];
            rsp.leaf_user     <= res_leaf[BIT_USER];
            rsp.leaf_frame    <= OUT_FRAME_BITS'(res_leaf[EW-1:FLAG_BITS]);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= TC_N && next_free != '0)
    else $error("table allocator out of range");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("table RAM written outside a walk");

  a_exhaust_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EXHAUSTED) |-> (!rsp.leaf_present && rsp.leaf_frame == '0))
    else $error("exhausted result carries leaf data");

  a_alloc_only_link: assert property (@(posedge clk) disable iff (rst)
    (state != S_LINK) |=> $stable(next_free))
    else $error("allocator moved outside link write");

endmodule
